// File: src/qtl_pkg.sv
// Package for the query token lexer: token kinds, lexer modes, constants.
`default_nettype none
package qtl_pkg;
    localparam int POSITION_BITS_DEF = 16;
    localparam int MAX_RESULTS = 3;

    typedef enum logic [4:0] {
        K_SPACE = 5'd0, K_STRING = 5'd1, K_OPEN = 5'd2, K_CLOSE = 5'd3, K_EQUALS = 5'd4,
        K_REGEX_EQ = 5'd5, K_ASSIGN = 5'd6, K_NOT = 5'd7, K_OR = 5'd8, K_BIT_OR = 5'd9,
        K_AND = 5'd10, K_BIT_AND = 5'd11, K_REGEXP = 5'd12, K_COMMA = 5'd13,
        K_CASE_FLAG = 5'd14, K_SIGNED = 5'd15, K_UNSIGNED = 5'd16, K_DECIMAL = 5'd17,
        K_KW_NULL = 5'd18, K_KW_QUERY = 5'd19, K_KW_CAT = 5'd20, K_KW_WHERE = 5'd21,
        K_KW_COLS = 5'd22, K_KW_VFILE = 5'd23, K_WORD = 5'd24, K_ILLEGAL = 5'd25,
        K_END = 5'd26
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE, M_SPACE, M_QUOTED, M_QCLOSE, M_OPER, M_IFLAG, M_MINUS,
        M_INT_S, M_INT_U, M_DOT_S, M_DOT_U, M_FRAC, M_IDENT
    } t_mode;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        empty_quoted;
        logic        last_of_run;
    } t_token;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_text;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_id(input logic [7:0] c);
        return c[7] || c == "$" || c == "_" || is_digit(c) ||
               (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // keyword character at a position, 0 where past the end
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
        logic [39:0] s;
        case (k)
            0: s = {"NULL", 8'd0};
            1: s = "QUERY";
            2: s = {"CAT", 16'd0};
            3: s = "WHERE";
            4: s = {"COLS", 8'd0};
            default: s = "vfile";
        endcase
        return s[8'(39 - 8 * int'(p)) -: 8];
    endfunction

    function automatic logic [2:0] kw_len(input int k);
        case (k)
            0, 4: return 3'd4;
            2: return 3'd3;
            default: return 3'd5;
        endcase
    endfunction
endpackage
`default_nettype wire

// File: src/qtl_if.sv
// Valid/ready channel interface carrying one payload word.
`default_nettype none
interface qtl_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/query_token_lexer.sv
// Query token lexer: one text byte per cycle in when not stalled, up to three tokens out.
// Results of a byte are registered and appear in the cycle after it is accepted.
// Throughput: one byte per cycle while the output side takes each word at once;
// a byte giving several tokens holds input until its extra tokens have been taken.
// Reset: synchronous active-low i_rst_n returns the lexer to idle at position 0.
// A final byte flushes the pending token, sends the end token and resets the state.
`default_nettype none
module query_token_lexer import qtl_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qtl_if.sink       i_text,
    qtl_if.source     o_token
);
    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] PMAX = '1;

    t_mode         r_mode, n_mode;
    logic [7:0]    r_delim, n_delim, r_held, n_held;
    logic [PB-1:0] r_start, n_start, r_len, n_len, r_pos, n_pos;
    logic [5:0]    r_cand, n_cand;

    // result queue of up to three words
    t_token       r_q [MAX_RESULTS];
    logic [1:0]   r_cnt;
    t_token       n_res [MAX_RESULTS];
    logic [1:0]   n_num;

    logic [7:0] c;
    logic       fin, acc;
    assign c   = i_text.data.text_byte;
    assign fin = i_text.data.final_byte;
    assign i_text.ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_token.ready);
    assign acc = i_text.valid && i_text.ready;
    assign o_token.valid = r_cnt != 2'd0;
    assign o_token.data  = r_q[0];

    function automatic logic [PB-1:0] sinc(input logic [PB-1:0] v);
        return v == PMAX ? PMAX : v + 1'b1;
    endfunction

    function automatic logic [15:0] clip(input logic [PB-1:0] v);
        logic [PB+15:0] w;
        w = {16'd0, v};
        return w > (PB+16)'(16'hffff) ? 16'hffff : w[15:0];
    endfunction

    function automatic logic [5:0] kw_step(input logic [5:0] cand, input logic [7:0] ch,
                                           input logic [PB-1:0] p);
        logic [5:0] r;
        logic [7:0] cc;
        r = cand;
        for (int k = 0; k < 6; k++) begin
            cc = ch;
            if (k < 5 && ch >= "a" && ch <= "z") cc = ch - 8'h20;
            if (p >= PB'(kw_len(k))) r[k] = 1'b0;
            else if (cc != kw_char(k, p[2:0])) r[k] = 1'b0;
        end
        return r;
    endfunction

    always_comb begin
        logic done, is_sp;
        logic [PB-1:0] dot;
        t_kind kd;
        n_mode = r_mode; n_delim = r_delim; n_held = r_held;
        n_start = r_start; n_len = r_len; n_pos = r_pos; n_cand = r_cand;
        n_num = 2'd0;
        done = 1'b0;
        kd = K_WORD;
        for (int i = 0; i < MAX_RESULTS; i++) n_res[i] = '0;
        dot = (r_start > PMAX - r_len) ? PMAX : r_start + r_len;
        is_sp = c == " " || (c >= 8'd9 && c <= 8'd13);
        for (int k = 5; k >= 0; k--)
            if (r_cand[k] && r_len == PB'(kw_len(k))) kd = t_kind'(5'(18 + k));

        if (!fin) begin
            case (r_mode)
                M_SPACE: if (is_sp) begin n_len = sinc(r_len); done = 1'b1; end
                M_QUOTED: begin
                    if (c == r_delim) n_mode = M_QCLOSE;
                    n_len = sinc(r_len); done = 1'b1;
                end
                M_QCLOSE: if (c == r_delim) begin
                    n_mode = M_QUOTED; n_len = sinc(r_len); done = 1'b1;
                end
                M_OPER: begin
                    if (r_held == "=" && (c == "=" || c == "~")) begin
                        n_res[0] = '{c == "=" ? K_EQUALS : K_REGEX_EQ, clip(r_start), 16'd2,
                                    1'b0, 1'b0};
                        n_num = 2'd1; n_mode = M_IDLE; done = 1'b1;
                    end else if ((r_held == "|" || r_held == "&") && c == r_held) begin
                        n_res[0] = '{r_held == "|" ? K_OR : K_AND, clip(r_start), 16'd2,
                                    1'b0, 1'b0};
                        n_num = 2'd1; n_mode = M_IDLE; done = 1'b1;
                    end
                end
                M_IFLAG, M_IDENT: if (is_id(c)) begin
                    n_cand = kw_step(r_cand, c, r_len);
                    n_len = sinc(r_len); n_mode = M_IDENT; done = 1'b1;
                end
                M_MINUS: if (is_digit(c)) begin
                    n_len = sinc(r_len); n_mode = M_INT_S; done = 1'b1;
                end
                M_INT_S, M_INT_U: begin
                    if (is_digit(c)) begin n_len = sinc(r_len); done = 1'b1; end
                    else if (c == ".") begin
                        n_mode = r_mode == M_INT_S ? M_DOT_S : M_DOT_U; done = 1'b1;
                    end
                end
                M_DOT_S, M_DOT_U: if (is_digit(c)) begin
                    n_len = sinc(sinc(r_len)); n_mode = M_FRAC; done = 1'b1;
                end
                M_FRAC: if (is_digit(c)) begin n_len = sinc(r_len); done = 1'b1; end
                default: ;
            endcase
        end

        // flush of the pending token
        if (fin || !done) begin
            case (r_mode)
                M_SPACE: begin n_res[0] = '{K_SPACE, clip(r_start), clip(r_len), 1'b0, 1'b0};
                    n_num = 2'd1; end
                M_QUOTED, M_QCLOSE: begin
                    n_res[0] = '{r_delim == "/" ? K_REGEXP : K_STRING, clip(r_start),
                                clip(r_len),
                                r_len == (r_mode == M_QUOTED ? PB'(1) : PB'(2)), 1'b0};
                    n_num = 2'd1;
                end
                M_OPER: begin
                    n_res[0] = '{r_held == "|" ? K_BIT_OR : r_held == "&" ? K_BIT_AND
                                : K_ASSIGN, clip(r_start), 16'd1, 1'b0, 1'b0};
                    n_num = 2'd1;
                end
                M_IFLAG: begin n_res[0] = '{K_CASE_FLAG, clip(r_start), 16'd1, 1'b0, 1'b0};
                    n_num = 2'd1; end
                M_MINUS: begin n_res[0] = '{K_ILLEGAL, clip(r_start), 16'd1, 1'b0, 1'b0};
                    n_num = 2'd1; end
                M_INT_S: begin n_res[0] = '{K_SIGNED, clip(r_start), clip(r_len), 1'b0, 1'b0};
                    n_num = 2'd1; end
                M_INT_U: begin
                    n_res[0] = '{K_UNSIGNED, clip(r_start), clip(r_len), 1'b0, 1'b0};
                    n_num = 2'd1;
                end
                M_DOT_S, M_DOT_U: begin
                    n_res[0] = '{r_mode == M_DOT_S ? K_SIGNED : K_UNSIGNED, clip(r_start),
                                clip(r_len), 1'b0, 1'b0};
                    n_res[1] = '{K_ILLEGAL, clip(dot), 16'd1, 1'b0, 1'b0};
                    n_num = 2'd2;
                end
                M_FRAC: begin
                    n_res[0] = '{K_DECIMAL, clip(r_start), clip(r_len), 1'b0, 1'b0};
                    n_num = 2'd1;
                end
                M_IDENT: begin n_res[0] = '{kd, clip(r_start), clip(r_len), 1'b0, 1'b0};
                    n_num = 2'd1; end
                default: ;
            endcase
            n_mode = M_IDLE;
        end

        if (fin) begin
            n_res[n_num] = '{K_END, clip(r_pos), 16'd0, 1'b0, 1'b0};
            n_num = n_num + 2'd1;
            n_mode = M_IDLE; n_delim = '0; n_start = '0; n_len = '0; n_pos = '0;
            n_cand = '1; n_held = '0;
        end else begin
            if (!done) begin
                n_start = r_pos;
                n_len = PB'(1);
                if (c == " " || c == 8'd9 || c == 8'd10 || c == 8'd13) n_mode = M_SPACE;
                else if (c == "\"" || c == "'" || c == "/") begin
                    n_delim = c; n_mode = M_QUOTED;
                end else if (c == "(" || c == ")" || c == "!" || c == ",") begin
                    n_res[n_num] = '{c == "(" ? K_OPEN : c == ")" ? K_CLOSE
                                     : c == "!" ? K_NOT : K_COMMA,
                                     clip(r_pos), 16'd1, 1'b0, 1'b0};
                    n_num = n_num + 2'd1;
                end else if (c == "=" || c == "|" || c == "&") begin
                    n_held = c; n_mode = M_OPER;
                end else if (c == "i") begin
                    n_cand = kw_step(6'h3f, c, '0); n_mode = M_IFLAG;
                end else if (is_digit(c)) n_mode = M_INT_U;
                else if (c == "-") n_mode = M_MINUS;
                else if (is_id(c)) begin
                    n_cand = kw_step(6'h3f, c, '0); n_mode = M_IDENT;
                end else begin
                    n_res[n_num] = '{K_ILLEGAL, clip(r_pos), 16'd1, 1'b0, 1'b0};
                    n_num = n_num + 2'd1;
                end
            end
            n_pos = sinc(r_pos);
        end
        if (n_num != 2'd0) n_res[n_num - 2'd1].last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_delim <= '0; r_held <= '0; r_start <= '0;
            r_len <= '0; r_pos <= '0; r_cand <= '1; r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_mode <= n_mode; r_delim <= n_delim; r_held <= n_held;
                r_start <= n_start; r_len <= n_len; r_pos <= n_pos; r_cand <= n_cand;
                r_cnt <= n_num;
                r_q <= n_res;
            end else if (o_token.valid && o_token.ready) begin
                r_cnt <= r_cnt - 2'd1;
                r_q[0] <= r_q[1];
                r_q[1] <= r_q[2];
            end
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for query_token_lexer: table-driven and random text against a token predictor.
`timescale 1ns / 1ps
module tb;
    import qtl_pkg::*;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        logic       chk;
        t_kind      kind;
        int         start;
        int         len;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qtl_if #(.T(t_text))  text_ch ();
    qtl_if #(.T(t_token)) tok_ch ();

    query_token_lexer DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_text (text_ch.sink),
        .o_token(tok_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lexer state mirrored by the predictor
    t_mode       lx_mode;
    logic [7:0]  lx_delim;
    logic [15:0] lx_start;
    logic [15:0] lx_run;
    logic [15:0] lx_pos;
    logic [5:0]  lx_cand;
    logic [7:0]  lx_held;

    t_token tokens_due[$];
    t_token step_toks[$];
    string  kw_word[6] = '{"NULL", "QUERY", "CAT", "WHERE", "COLS", "vfile"};

    int errors = 0;
    int cycles = 0;
    bit text_done = 0;

    function automatic logic [15:0] sat1(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit id_char(input logic [7:0] c);
        return c[7] || c == "$" || c == "_" || digit(c) ||
               (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [5:0] narrow_kw(input logic [5:0] cand, input logic [7:0] c,
                                             input logic [15:0] p);
        logic [7:0] cc;
        for (int k = 0; k < 6; k++) begin
            if (!cand[k]) continue;
            if (p >= kw_word[k].len()) begin
                cand[k] = 1'b0;
                continue;
            end
            cc = c;
            if (k < 5 && cc >= "a" && cc <= "z") cc = cc - 8'h20;
            if (cc != kw_word[k][p]) cand[k] = 1'b0;
        end
        return cand;
    endfunction

    function automatic void put_tok(input t_kind k, input logic [15:0] s, input logic [15:0] l,
                                    input logic e);
        t_token t;
        if (step_toks.size() >= MAX_RESULTS) return;
        t.token_kind = k;
        t.token_start = s;
        t.token_length = l;
        t.empty_quoted = e;
        t.last_of_run = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic t_kind word_kind();
        for (int k = 0; k < 6; k++)
            if (lx_cand[k] && lx_run == kw_word[k].len()) return t_kind'(int'(K_KW_NULL) + k);
        return K_WORD;
    endfunction

    function automatic void flush_pending();
        t_kind qk;
        logic [16:0] dot;
        qk = (lx_delim == "/") ? K_REGEXP : K_STRING;
        case (lx_mode)
            M_SPACE:  put_tok(K_SPACE, lx_start, lx_run, 1'b0);
            M_QUOTED: put_tok(qk, lx_start, lx_run, lx_run == 16'd1);
            M_QCLOSE: put_tok(qk, lx_start, lx_run, lx_run == 16'd2);
            M_OPER:   put_tok(lx_held == "|" ? K_BIT_OR : lx_held == "&" ? K_BIT_AND : K_ASSIGN,
                              lx_start, 16'd1, 1'b0);
            M_IFLAG:  put_tok(K_CASE_FLAG, lx_start, 16'd1, 1'b0);
            M_MINUS:  put_tok(K_ILLEGAL, lx_start, 16'd1, 1'b0);
            M_INT_S:  put_tok(K_SIGNED, lx_start, lx_run, 1'b0);
            M_INT_U:  put_tok(K_UNSIGNED, lx_start, lx_run, 1'b0);
            M_DOT_S, M_DOT_U: begin
                dot = {1'b0, lx_start} + {1'b0, lx_run};
                if (dot[16]) dot = 17'hFFFF;
                put_tok(lx_mode == M_DOT_S ? K_SIGNED : K_UNSIGNED, lx_start, lx_run, 1'b0);
                put_tok(K_ILLEGAL, dot[15:0], 16'd1, 1'b0);
            end
            M_FRAC:   put_tok(K_DECIMAL, lx_start, lx_run, 1'b0);
            M_IDENT:  put_tok(word_kind(), lx_start, lx_run, 1'b0);
            default: ;
        endcase
        lx_mode = M_IDLE;
    endfunction

    // true when the pending token takes the byte
    function automatic bit absorb(input logic [7:0] c);
        case (lx_mode)
            M_IDLE: return 0;
            M_SPACE: if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
                lx_run = sat1(lx_run);
                return 1;
            end
            M_QUOTED: begin
                if (c == lx_delim) lx_mode = M_QCLOSE;
                lx_run = sat1(lx_run);
                return 1;
            end
            M_QCLOSE: if (c == lx_delim) begin
                lx_mode = M_QUOTED;
                lx_run = sat1(lx_run);
                return 1;
            end
            M_OPER: begin
                if (lx_held == "=" && (c == "=" || c == "~")) begin
                    put_tok(c == "=" ? K_EQUALS : K_REGEX_EQ, lx_start, 16'd2, 1'b0);
                    lx_mode = M_IDLE;
                    return 1;
                end
                if ((lx_held == "|" || lx_held == "&") && c == lx_held) begin
                    put_tok(lx_held == "|" ? K_OR : K_AND, lx_start, 16'd2, 1'b0);
                    lx_mode = M_IDLE;
                    return 1;
                end
            end
            M_IFLAG, M_IDENT: if (id_char(c)) begin
                lx_cand = narrow_kw(lx_cand, c, lx_run);
                lx_run = sat1(lx_run);
                lx_mode = M_IDENT;
                return 1;
            end
            M_MINUS: if (digit(c)) begin
                lx_run = sat1(lx_run);
                lx_mode = M_INT_S;
                return 1;
            end
            M_INT_S, M_INT_U: begin
                if (digit(c)) begin
                    lx_run = sat1(lx_run);
                    return 1;
                end
                if (c == ".") begin
                    lx_mode = (lx_mode == M_INT_S) ? M_DOT_S : M_DOT_U;
                    return 1;
                end
            end
            M_DOT_S, M_DOT_U: if (digit(c)) begin
                lx_run = sat1(sat1(lx_run));
                lx_mode = M_FRAC;
                return 1;
            end
            M_FRAC: if (digit(c)) begin
                lx_run = sat1(lx_run);
                return 1;
            end
            default: ;
        endcase
        flush_pending();
        return 0;
    endfunction

    function automatic void open_token(input logic [7:0] c, input logic [15:0] p);
        lx_start = p;
        lx_run = 16'd1;
        lx_mode = M_IDLE;
        if (c == " " || c == 8'd9 || c == 8'd10 || c == 8'd13) lx_mode = M_SPACE;
        else if (c == "\"" || c == "'" || c == "/") begin
            lx_delim = c;
            lx_mode = M_QUOTED;
        end
        else if (c == "(") put_tok(K_OPEN, p, 16'd1, 1'b0);
        else if (c == ")") put_tok(K_CLOSE, p, 16'd1, 1'b0);
        else if (c == "!") put_tok(K_NOT, p, 16'd1, 1'b0);
        else if (c == ",") put_tok(K_COMMA, p, 16'd1, 1'b0);
        else if (c == "=" || c == "|" || c == "&") begin
            lx_held = c;
            lx_mode = M_OPER;
        end
        else if (c == "i") begin
            lx_cand = narrow_kw(6'h3F, c, 16'd0);
            lx_mode = M_IFLAG;
        end
        else if (digit(c)) lx_mode = M_INT_U;
        else if (c == "-") lx_mode = M_MINUS;
        else if (id_char(c)) begin
            lx_cand = narrow_kw(6'h3F, c, 16'd0);
            lx_mode = M_IDENT;
        end
        else put_tok(K_ILLEGAL, p, 16'd1, 1'b0);
    endfunction

    function automatic void lexer_clear();
        lx_mode = M_IDLE;
        lx_delim = 8'd0;
        lx_start = 16'd0;
        lx_run = 16'd0;
        lx_pos = 16'd0;
        lx_cand = 6'h3F;
        lx_held = 8'd0;
    endfunction

    // tokens caused by one accepted word, appended to tokens_due
    function automatic void lex_word(input logic [7:0] c, input logic fin);
        step_toks.delete();
        if (fin) begin
            flush_pending();
            put_tok(K_END, lx_pos, 16'd0, 1'b0);
            lexer_clear();
        end else begin
            if (!absorb(c)) open_token(c, lx_pos);
            lx_pos = sat1(lx_pos);
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
        foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
    endfunction

    task automatic send_word(input logic [7:0] c, input logic fin);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 1)) gap = 0;
        if (gap > 0) begin
            text_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        text_ch.valid = 1'b1;
        text_ch.data = '{text_byte: c, final_byte: fin};
        forever begin
            @(posedge i_clk);
            if (text_ch.ready) break;
        end
        lex_word(c, fin);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    endtask

    function automatic string rand_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if ($urandom_range(0, 1) && r[i] >= "A" && r[i] <= "Z") r[i] = r[i] + 8'h20;
        return r;
    endfunction

    function automatic string rand_digits(input int n);
        string r;
        r = "";
        for (int i = 0; i < n; i++) r = {r, string'(8'($urandom_range("0", "9")))};
        return r;
    endfunction

    function automatic string rand_ident();
        string r;
        byte pool[] = '{"a", "z", "A", "Z", "_", "$", "0", "9", "i", "e", 8'h80, 8'hFE};
        r = "";
        for (int i = $urandom_range(1, 6); i > 0; i--)
            r = {r, string'(pool[$urandom_range(0, pool.size() - 1)])};
        return r;
    endfunction

    function automatic string rand_fragment();
        string q;
        string s;
        case ($urandom_range(0, 19))
            0: return rand_case(kw_word[$urandom_range(0, 4)]);
            1: begin
                s = "vFile";
                if ($urandom_range(0, 1)) s = "vfile";
                return s;
            end
            2: begin
                s = rand_case(kw_word[$urandom_range(0, 4)]);
                if ($urandom_range(0, 1)) s = {s, "S"};
                return s;
            end
            3: return rand_ident();
            4: return rand_digits($urandom_range(1, 4));
            5: return {"-", rand_digits($urandom_range(0, 3))};
            6: return {rand_digits($urandom_range(1, 3)), ".", rand_digits($urandom_range(0, 2))};
            7: begin
                if ($urandom_range(0, 2) == 0) q = "/";
                else if ($urandom_range(0, 1)) q = "'";
                else q = "\"";
                s = {q, rand_ident(), q, q};
                if ($urandom_range(0, 1)) s = {s, rand_ident(), q};
                return s;
            end
            8: begin
                q = "/";
                if ($urandom_range(0, 1)) q = "'";
                s = {q, "x y"};
                if ($urandom_range(0, 1)) s = {q, q};
                return s;
            end
            9: begin
                string ops[] = '{"==", "=~", "=", "||", "|", "&&", "&", "(", ")", "!", ","};
                return ops[$urandom_range(0, ops.size() - 1)];
            end
            10: begin
                s = "i";
                if ($urandom_range(0, 1)) s = {s, rand_ident()};
                return s;
            end
            11: begin
                byte ws[] = '{" ", 8'd9, 8'd10, 8'd13, 8'd11, 8'd12};
                q = " ";
                for (int i = $urandom_range(0, 3); i > 0; i--)
                    q = {q, string'(ws[$urandom_range(0, ws.size() - 1)])};
                return q;
            end
            12: return string'(8'($urandom_range(0, 255)));
            13: return $urandom_range(0, 1) ? string'(8'd11) : string'(8'd12);
            default: return " ";
        endcase
    endfunction

    t_row dir_rows[$] = '{
        '{"(", 0, 1, K_OPEN, 0, 1},
        '{")", 0, 1, K_CLOSE, 1, 1},
        '{"!", 0, 1, K_NOT, 2, 1},
        '{",", 0, 1, K_COMMA, 3, 1},
        '{"=", 0, 0, K_END, 0, 0},
        '{"=", 0, 1, K_EQUALS, 4, 2},
        '{"=", 0, 0, K_END, 0, 0},
        '{"~", 0, 1, K_REGEX_EQ, 6, 2},
        '{"|", 0, 0, K_END, 0, 0},
        '{"&", 0, 1, K_BIT_OR, 8, 1},
        '{"&", 0, 1, K_AND, 9, 2},
        '{8'h00, 0, 1, K_ILLEGAL, 11, 1},
        '{8'hFF, 0, 0, K_END, 0, 0},
        '{8'd11, 0, 0, K_END, 0, 0},
        '{"-", 0, 0, K_END, 0, 0},
        '{"x", 0, 0, K_END, 0, 0},
        '{"'", 0, 0, K_END, 0, 0},
        '{"'", 0, 0, K_END, 0, 0},
        '{"'", 0, 0, K_END, 0, 0},
        '{"=", 1, 0, K_END, 0, 0},
        '{"i", 0, 0, K_END, 0, 0},
        '{" ", 0, 1, K_CASE_FLAG, 0, 1},
        '{"7", 0, 0, K_END, 0, 0},
        '{".", 0, 0, K_END, 0, 0},
        '{8'h00, 1, 0, K_END, 0, 0}
    };

    initial begin
        int items;
        text_ch.valid = 1'b0;
        text_ch.data = '0;
        lexer_clear();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            send_word(dir_rows[r].b, dir_rows[r].fin);
            if (dir_rows[r].chk && (step_toks.size() == 0 ||
                    step_toks[0].token_kind != dir_rows[r].kind ||
                    step_toks[0].token_start != 16'(dir_rows[r].start) ||
                    step_toks[0].token_length != 16'(dir_rows[r].len))) begin
                errors++;
                if (errors <= 10)
                    $display("table row %0d: predicted token differs from kind %0d at %0d len %0d",
                             r, dir_rows[r].kind, dir_rows[r].start, dir_rows[r].len);
            end
        end

        items = 0;
        while (items < 360) begin
            string frag;
            frag = rand_fragment();
            send_text(frag);
            items += frag.len();
            if ($urandom_range(0, 7) == 0) begin
                send_word(8'($urandom_range(0, 255)), 1'b1);
                items++;
            end
        end
        send_word(8'hA5, 1'b1);
        text_ch.valid = 1'b0;
        text_done = 1;
    end

    // token side: random stalls, compare each word with the oldest prediction
    initial begin
        t_token want, got;
        tok_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            tok_ch.ready = 1'b0;
            if ($urandom_range(0, 1)) repeat ($urandom_range(0, 12)) @(negedge i_clk);
            tok_ch.ready = 1'b1;
            forever begin
                @(posedge i_clk);
                if (tok_ch.valid) break;
            end
            got = tok_ch.data;
            if (tokens_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected token word %p", got);
            end else begin
                want = tokens_due.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("token word: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 300000) begin
            $display("query_token_lexer: mismatch");
            $finish;
        end
    end

    initial begin
        wait (text_done);
        wait (tokens_due.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && tokens_due.size() == 0) begin
            $display("query_token_lexer: match");
        end else begin
            $display("query_token_lexer: mismatch");
        end
        $finish;
    end
endmodule
